FILE: src/hmlp_pkg.sv
// Package with the constants and types of the hash multiset core.
package hmlp_pkg;

   localparam int CAPACITY_DEF  = 1024;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int IN_KEY_W      = 32;
   localparam int SLOT_W        = 10;
   localparam int ENTRIES_W     = 11;
   localparam int ACTION_W      = 2;
   localparam logic [ENTRIES_W-1:0] MAX_ENTRIES_RESET = 11'd614;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_INS_WR,
      ST_DEL_WR,
      ST_FIX_RD,
      ST_FIX,
      ST_PLACE_RD,
      ST_PLACE,
      ST_RESP
   } state_type;

endpackage

FILE: src/hmlp_if.sv
// Valid/ready channel interfaces of the hash multiset core.
interface hmlp_req_if;
   import hmlp_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [IN_KEY_W-1:0] key;
   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

interface hmlp_rsp_if;
   import hmlp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 status;
   logic                 was_present;
   logic [SLOT_W-1:0]    slot;
   logic [ENTRIES_W-1:0] entries;
   modport source (output valid, output status, output was_present, output slot,
                   output entries, input ready);
   modport sink   (input valid, input status, input was_present, input slot,
                   input entries, output ready);
endinterface

interface hmlp_csr_if;
   import hmlp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ENTRIES_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/hash_multiset_linear_probe_core.sv
// Top level of the hash multiset core: sequencer, key memory and occupancy memory.
//
// Fixed-capacity hash multiset with linear probing. One request is handled at a
// time; the core probes one slot at a time, a read state then a check state,
// through a single memory read port and a single key comparator, and a remove
// re-places every displaced entry of the following cluster
// (each re-placement probes again from its home).
// After reset the occupancy memory is swept, one slot a cycle, during which no
// request is accepted; limit writes are taken at any time.
module hash_multiset_linear_probe_core
#(
   parameter int CAPACITY  = hmlp_pkg::CAPACITY_DEF,
   parameter int KEY_WIDTH = hmlp_pkg::KEY_WIDTH_DEF
)
(
   input logic         clock,
   input logic         reset,
   hmlp_req_if.sink    req,
   hmlp_rsp_if.source  rsp,
   hmlp_csr_if.sink    csr
);
   import hmlp_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KEY_WIDTH-1:0] key_mem [CAPACITY];
   logic                 occ_mem [CAPACITY];

   state_type state_ff, state_in;
   logic [ENTRIES_W-1:0] max_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [1:0]           act_ff, act_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        last_ff, last_in;
   logic [AW-1:0]        fix_ff, fix_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        fn_ff, fn_in;
   logic                 hit_ff, hit_in;
   logic                 status_ff, status_in;
   logic                 pres_ff, pres_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 rvalid_ff;

   logic [KEY_WIDTH-1:0] rd_key_ff;
   logic                 rd_occ_ff;
   logic [AW-1:0]        rd_addr;
   logic                 kw_en, ow_en, ow_val;
   logic [AW-1:0]        w_addr;
   logic [KEY_WIDTH-1:0] kw_data;

   logic [KEY_WIDTH-1:0] in_key;
   logic                 key_eq;
   logic [AW-1:0]        ptr_nx;

   function automatic logic [AW-1:0] home(input logic [KEY_WIDTH-1:0] k);
      // Sign extension to 64 bits then modulo a power of two is the low bits;
      // other capacities use a 64-bit modulo by a constant.
      logic [63:0] wide;
      wide = {{(64-KEY_WIDTH){k[KEY_WIDTH-1]}}, k};
      return AW'(wide % 64'(CAPACITY));
   endfunction

   assign in_key = (KEY_WIDTH <= IN_KEY_W) ? KEY_WIDTH'(req.key)
                 : KEY_WIDTH'({{(64-IN_KEY_W){req.key[IN_KEY_W-1]}}, req.key});
   assign key_eq = (rd_key_ff == key_ff);
   assign ptr_nx = (ptr_ff == AW'(CAPACITY-1)) ? '0 : ptr_ff + 1'b1;

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rvalid_ff;
   assign rsp.status = status_ff;
   assign rsp.was_present = pres_ff;
   assign rsp.slot = slot_ff;
   assign rsp.entries = ENTRIES_W'(count_ff);

   // Memories: one read port registered, one write port.
   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_occ_ff <= occ_mem[rd_addr];
      if (kw_en) key_mem[w_addr] <= kw_data;
      if (ow_en) occ_mem[w_addr] <= ow_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         max_ff    <= MAX_ENTRIES_RESET;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         ptr_ff    <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
         if (csr.valid) max_ff <= csr.data;
         if (state_ff == ST_RESP) rvalid_ff <= 1'b1;
         else if (rsp.ready) rvalid_ff <= 1'b0;
      end
      key_ff <= key_in;   act_ff <= act_in;   last_ff <= last_in;
      fix_ff <= fix_in;   n_ff <= n_in;       fn_ff <= fn_in;
      hit_ff <= hit_in;   status_ff <= status_in;
      pres_ff <= pres_in; slot_ff <= slot_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (ptr_ff == AW'(CAPACITY-1)) state_in = ST_IDLE;
         ST_IDLE:     if (req.valid && req.ready) state_in = ST_SCAN_RD;
         ST_SCAN_RD:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (!rd_occ_ff || n_ff == CW'(CAPACITY)) begin
               if (act_ff == ACT_INSERT && !status_ff && rd_occ_ff == 1'b0)
                  state_in = ST_INS_WR;
               else if (act_ff == ACT_REMOVE && hit_ff) state_in = ST_DEL_WR;
               else state_in = ST_RESP;
            end else if (act_ff == ACT_FIND && key_eq) state_in = ST_RESP;
            else if (act_ff == ACT_INSERT && status_ff && key_eq) state_in = ST_RESP;
            else state_in = ST_SCAN_RD;
         end
         ST_INS_WR:   state_in = ST_RESP;
         ST_DEL_WR:   state_in = ST_FIX_RD;
         ST_FIX_RD:   state_in = ST_FIX;
         ST_FIX: begin
            if (!rd_occ_ff || fn_ff == CW'(CAPACITY)) state_in = ST_RESP;
            else if (home(rd_key_ff) != fix_ff) state_in = ST_PLACE_RD;
            else state_in = ST_FIX_RD;
         end
         ST_PLACE_RD: state_in = ST_PLACE;
         ST_PLACE:    state_in = rd_occ_ff ? ST_PLACE_RD : ST_FIX_RD;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      count_in = count_ff;  key_in = key_ff;   act_in = act_ff;
      ptr_in = ptr_ff;      last_in = last_ff; fix_in = fix_ff;
      n_in = n_ff;          fn_in = fn_ff;     hit_in = hit_ff;
      status_in = status_ff; pres_in = pres_ff; slot_in = slot_ff;
      rd_addr = ptr_ff;
      kw_en = 1'b0; ow_en = 1'b0; ow_val = 1'b0;
      w_addr = ptr_ff; kw_data = key_ff;
      case (state_ff)
         ST_CLEAR: begin
            ow_en  = 1'b1;
            ptr_in = ptr_nx;
         end
         ST_IDLE: begin
            // The result registers hold a waiting response until a new request arrives.
            if (req.valid && req.ready) begin
               key_in = in_key;
               act_in = req.action;
               ptr_in = home(in_key);
               n_in = '0; hit_in = 1'b0; pres_in = 1'b0; slot_in = '0;
               status_in = (req.action == ACT_INSERT) &&
                           ((count_ff >= CW'(max_ff)) || (count_ff >= CW'(CAPACITY)));
            end
         end
         ST_SCAN_RD: begin
            // An unknown action or a remove on an empty table probes nothing.
            if (act_ff == ACT_NONE || (act_ff == ACT_REMOVE && count_ff == '0))
               n_in = CW'(CAPACITY);
         end
         ST_SCAN: begin
            if (rd_occ_ff && n_ff != CW'(CAPACITY)) begin
               if (key_eq) begin
                  pres_in = 1'b1;
                  hit_in = 1'b1;
                  last_in = ptr_ff;
                  if (act_ff == ACT_FIND) slot_in = SLOT_W'(ptr_ff);
               end
               ptr_in = ptr_nx;
               n_in = n_ff + 1'b1;
            end
         end
         ST_INS_WR: begin
            kw_en = 1'b1; ow_en = 1'b1; ow_val = 1'b1;
            slot_in = SLOT_W'(ptr_ff);
            count_in = count_ff + 1'b1;
         end
         ST_DEL_WR: begin
            kw_en = 1'b1; kw_data = '0; ow_en = 1'b1; w_addr = last_ff;
            slot_in = SLOT_W'(last_ff);
            count_in = count_ff - 1'b1;
            fix_in = (last_ff == AW'(CAPACITY-1)) ? '0 : last_ff + 1'b1;
            fn_in = '0;
         end
         ST_FIX_RD: rd_addr = fix_ff;
         ST_FIX: begin
            rd_addr = fix_ff;
            if (rd_occ_ff && fn_ff != CW'(CAPACITY)) begin
               if (home(rd_key_ff) != fix_ff) begin
                  // Lift the entry out, then probe from its home for a free slot.
                  ow_en = 1'b1; w_addr = fix_ff;
                  key_in = rd_key_ff;
                  ptr_in = home(rd_key_ff);
               end else begin
                  fix_in = (fix_ff == AW'(CAPACITY-1)) ? '0 : fix_ff + 1'b1;
                  fn_in = fn_ff + 1'b1;
               end
            end
         end
         ST_PLACE_RD: rd_addr = ptr_ff;
         ST_PLACE: begin
            if (rd_occ_ff) ptr_in = ptr_nx;
            else begin
               kw_en = 1'b1; ow_en = 1'b1; ow_val = 1'b1;
               fix_in = (fix_ff == AW'(CAPACITY-1)) ? '0 : fix_ff + 1'b1;
               fn_in = fn_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RESP |=> rvalid_ff) else $error("result lost");
   a_reject_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && status_ff) |=> state_ff != ST_INS_WR)
      else $error("rejected insert wrote");
endmodule

FILE: tb/sv/tb_hash_multiset_linear_probe_core.sv
// Self-checking testbench of the hash multiset core with linear probing.
`timescale 1ns / 100ps

module tb_hash_multiset_linear_probe_core;
   import hmlp_pkg::*;

   localparam int SLOTS          = 1024;
   localparam int WATCHDOG_LIMIT = 500000;

   typedef struct packed {
      logic                 status;
      logic                 was_present;
      logic [SLOT_W-1:0]    slot;
      logic [ENTRIES_W-1:0] entries;
   } outcome_type;

   logic clock;
   logic reset;

   hmlp_req_if req ();
   hmlp_rsp_if rsp ();
   hmlp_csr_if csr ();

   hash_multiset_linear_probe_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   // Shadow copy of the table.
   logic [31:0]          shadow_key  [SLOTS];
   bit                   shadow_used [SLOTS];
   int unsigned          shadow_count;
   int unsigned          shadow_limit;

   outcome_type          pending_outcomes[$];
   logic [31:0]          key_pool[64];
   int                   error_count;
   int                   idle_cycles;
   int                   send_idle_pct;
   int                   stall_pct;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [SLOT_W-1:0] home_slot(logic [31:0] k);
      return k[SLOT_W-1:0];
   endfunction

   function automatic bit lookup_key(logic [31:0] k, output logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] h;
      h = home_slot(k);
      s = '0;
      for (int n = 0; n < SLOTS && shadow_used[h]; n++) begin
         if (shadow_key[h] == k) begin
            s = h;
            return 1'b1;
         end
         h = h + 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [SLOT_W-1:0] place_key(logic [31:0] k, output bit dup);
      logic [SLOT_W-1:0] h;
      int n;
      h = home_slot(k);
      n = 0;
      dup = 1'b0;
      while (shadow_used[h] && n < SLOTS) begin
         if (shadow_key[h] == k) dup = 1'b1;
         h = h + 1'b1;
         n++;
      end
      shadow_key[h]  = k;
      shadow_used[h] = 1'b1;
      return h;
   endfunction

   // Applies one request to the shadow table and gives the outcome it should produce.
   function automatic outcome_type apply_request(action_type act, logic [31:0] k);
      outcome_type o;
      logic [SLOT_W-1:0] h, last, s;
      bit dup, hit;
      int n;
      o = '0;
      case (act)
         ACT_INSERT: begin
            if (shadow_count >= shadow_limit || shadow_count >= SLOTS) begin
               o.status      = 1'b1;
               o.was_present = lookup_key(k, s);
            end else begin
               o.slot        = place_key(k, dup);
               o.was_present = dup;
               shadow_count++;
            end
         end
         ACT_REMOVE: begin
            if (shadow_count != 0) begin
               h = home_slot(k);
               n = 0;
               hit = 1'b0;
               last = '0;
               while (shadow_used[h] && n < SLOTS) begin
                  if (shadow_key[h] == k) begin
                     last = h;
                     hit = 1'b1;
                  end
                  h = h + 1'b1;
                  n++;
               end
               if (hit) begin
                  shadow_key[last]  = '0;
                  shadow_used[last] = 1'b0;
                  h = last + 1'b1;
                  // Entries displaced from home are lifted out and placed again.
                  for (n = 0; shadow_used[h] && n < SLOTS; n++) begin
                     if (home_slot(shadow_key[h]) != h) begin
                        shadow_used[h] = 1'b0;
                        void'(place_key(shadow_key[h], dup));
                     end
                     h = h + 1'b1;
                  end
                  shadow_count--;
                  o.was_present = 1'b1;
                  o.slot        = last;
               end
            end
         end
         ACT_FIND: o.was_present = lookup_key(k, o.slot);
         default: ;
      endcase
      o.entries = shadow_count[ENTRIES_W-1:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic send_request(action_type act, logic [31:0] k);
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid  = 1'b1;
      req.action = act;
      req.key    = k;
      do @(posedge clock); while (!req.ready);
      pending_outcomes.insert(pending_outcomes.size(), apply_request(act, k));
   endtask

   task automatic drain_outcomes();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [ENTRIES_W-1:0] value);
      @(negedge clock);
      csr.valid = 1'b1;
      csr.data  = value;
      do @(posedge clock); while (!csr.ready);
      shadow_limit = value;
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // Checks each response against the oldest outstanding outcome; also the watchdog.
   initial begin
      outcome_type want;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (csr.valid && csr.ready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp.valid && rsp.ready) begin
            idle_cycles = 0;
            if (pending_outcomes.size() == 0) begin
               $display("%0t: response with no request outstanding", $realtime);
               error_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp.status !== want.status)
                  report_mismatch("status", rsp.status, want.status);
               if (rsp.was_present !== want.was_present)
                  report_mismatch("was_present", rsp.was_present, want.was_present);
               if (rsp.slot !== want.slot)
                  report_mismatch("slot", rsp.slot, want.slot);
               if (rsp.entries !== want.entries)
                  report_mismatch("entries", rsp.entries, want.entries);
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_hash_multiset_linear_probe_core failed");
            $finish;
         end
      end
   end

   initial begin
      rsp.ready = 1'b1;
      forever begin
         @(negedge clock);
         rsp.ready = !(stall_pct > 0 && $urandom_range(99) < stall_pct);
      end
   end

   task automatic test_directed();
      write_limit(11'd1024);
      send_request(ACT_REMOVE, 32'd5);          // empty table
      send_request(ACT_FIND, 32'd5);
      send_request(ACT_INSERT, 32'h0000_0000);
      send_request(ACT_INSERT, 32'hFFFF_FFFF);
      send_request(ACT_INSERT, 32'h7FFF_FFFF);
      send_request(ACT_INSERT, 32'h8000_0000);
      send_request(ACT_INSERT, 32'h8000_0000);  // duplicate, probes past home
      send_request(ACT_INSERT, 32'h0000_07FF);  // cluster wraps round the end
      send_request(ACT_FIND, 32'h8000_0000);
      send_request(ACT_FIND, 32'h0000_07FF);
      send_request(ACT_FIND, 32'h1234_5678);    // absent key
      send_request(ACT_NONE, 32'h7FFF_FFFF);
      send_request(ACT_REMOVE, 32'h8000_0000);  // last duplicate, cluster re-placed
      send_request(ACT_REMOVE, 32'hFFFF_FFFF);
      send_request(ACT_FIND, 32'h0000_07FF);
      send_request(ACT_REMOVE, 32'h5555_AAAA);  // absent key
      drain_outcomes();
   endtask

   task automatic test_limit_extremes();
      write_limit(11'd1);                       // table already above the limit
      send_request(ACT_INSERT, 32'h0000_07FF);
      send_request(ACT_INSERT, 32'h0000_0123);
      drain_outcomes();
      write_limit(11'd0);
      send_request(ACT_INSERT, 32'h8000_0000);
      drain_outcomes();
      write_limit(11'd2047);
      send_request(ACT_INSERT, 32'hAAAA_5555);
      send_request(ACT_REMOVE, 32'hAAAA_5555);
      drain_outcomes();
   endtask

   task automatic test_random(int items, int idle_pct, int stall, int limit);
      action_type act;
      logic [31:0] k;
      int pick;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      write_limit(limit[ENTRIES_W-1:0]);
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 12) begin
            act = action_type'($urandom_range(3));
            k   = $urandom;
         end else begin
            k = key_pool[$urandom_range(63)];
            pick = $urandom_range(99);
            act = pick < 38 ? ACT_INSERT : pick < 78 ? ACT_REMOVE :
                  pick < 96 ? ACT_FIND : ACT_NONE;
         end
         send_request(act, k);
      end
      drain_outcomes();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      logic [SLOT_W-1:0] h;
      reset        = 1'b1;
      req.valid    = 1'b0;
      req.action   = ACT_NONE;
      req.key      = '0;
      csr.valid    = 1'b0;
      csr.data     = '0;
      error_count  = 0;
      idle_cycles  = 0;
      send_idle_pct = 0;
      stall_pct    = 0;
      shadow_count = 0;
      shadow_limit = MAX_ENTRIES_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         shadow_used[i] = 1'b0;
         shadow_key[i]  = '0;
      end
      // Keys with homes in a narrow window across the end of the table, so that
      // clusters form and wrap.
      for (int i = 0; i < 64; i++) begin
         h = SLOT_W'(1000 + $urandom_range(47));
         key_pool[i] = {22'($urandom), h};
      end
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_limit_extremes();
      test_random(240, 0, 0, 40);
      test_random(230, 67, 0, 1024);
      test_random(230, 0, 67, 64);
      test_random(230, 26, 26, 614);

      drain_outcomes();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_hash_multiset_linear_probe_core passed");
      end else begin
         $display("tb_hash_multiset_linear_probe_core failed");
      end
      $finish;
   end

endmodule
